// File: src/spq_pkg.sv
// Shared types, constants and index helpers for the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 8;

    localparam int PRIO_W = PRIORITY_BITS;
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SUM_W  = CNT_W + 1;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] item_value;
        logic [7:0]         item_priority;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_value;
        logic [7:0]         out_priority;
        logic               last;
    } result_t;

    // One stored queue entry
    typedef struct packed {
        logic [31:0]       value;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Storage access from the sequencer
    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        entry_t             wdata;
        logic [ADDR_W-1:0]  raddr;
    } ram_req_t;

    // Result beat handed to the output register
    typedef struct packed {
        logic    valid;
        result_t res;
    } emit_t;

    // Port priority to stored width (keeps the low PRIO_W bits)
    function automatic logic [PRIO_W-1:0] to_prio(input logic [7:0] p);
        logic [PRIO_W+7:0] tmp;
        tmp = {{PRIO_W{1'b0}}, p};
        return tmp[PRIO_W-1:0];
    endfunction

    // Stored priority back to the 8-bit port
    function automatic logic [7:0] from_prio(input logic [PRIO_W-1:0] p);
        logic [PRIO_W+7:0] tmp;
        tmp = {8'd0, p};
        return tmp[7:0];
    endfunction

    // Circular index: base + offset, wrapped at CAPACITY
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  offs);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(offs);
        if (s >= SUM_W'(CAPACITY))
            s = s - SUM_W'(CAPACITY);
        return s[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(CAPACITY - 1)) ? '0 : p + ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] p);
        return (p == '0) ? ADDR_W'(CAPACITY - 1) : p - ADDR_W'(1);
    endfunction

endpackage

// File: src/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/spq_seq.sv
// Command sequencer: circular sorted store, insertion scan with one comparator.
module spq_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  spq_pkg::item_t    item,
    input  spq_pkg::entry_t   ram_rdata,
    output logic              busy,
    output spq_pkg::ram_req_t ram_req,
    output spq_pkg::emit_t    emit
);
    import spq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_INS_RD   = 7'b0000010,
        S_INS_CMP  = 7'b0000100,
        S_REM_RD   = 7'b0001000,
        S_REM_OUT  = 7'b0010000,
        S_DUMP_RD  = 7'b0100000,
        S_DUMP_OUT = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] wptr_reg, wptr_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    entry_t            ent_reg, ent_next;
    logic              shift_up;

    // Comparator: stored entry belongs after the new one
    assign shift_up = ram_rdata.prio > ent_reg.prio;

    assign busy = (state_reg != S_IDLE);

    // Sequencer next state and storage access
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        head_next  = head_reg;
        ptr_next   = ptr_reg;
        wptr_next  = wptr_reg;
        rem_next   = rem_reg;
        ent_next   = ent_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = wptr_reg;
        ram_req.wdata = ent_reg;
        ram_req.raddr = ptr_reg;

        emit.valid            = 1'b0;
        emit.res.status       = STAT_OK;
        emit.res.out_value    = '0;
        emit.res.out_priority = '0;
        emit.res.last         = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ent_next.value = item.item_value;
                    ent_next.prio  = to_prio(item.item_priority);
                    unique case (item.cmd)
                        CMD_INSERT:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                emit.valid      = 1'b1;
                                emit.res.status = STAT_FULL;
                            end
                            else
                            begin
                                wptr_next  = wrap_add(head_reg, count_reg);
                                ptr_next   = wrap_dec(wrap_add(head_reg, count_reg));
                                rem_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                emit.valid      = 1'b1;
                                emit.res.status = STAT_EMPTY;
                            end
                            else
                                state_next = S_REM_RD;
                        end
                        CMD_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                emit.valid      = 1'b1;
                                emit.res.status = STAT_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = head_reg;
                                rem_next   = count_reg;
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                            emit.valid = 1'b1;
                    endcase
                end
            end
            // Read the next lower entry, or drop the new one in when none left
            S_INS_RD:
            begin
                if (rem_reg == '0)
                begin
                    ram_req.we = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    emit.valid = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_INS_CMP;
            end
            // Move the entry up a slot, or place the new entry above it
            S_INS_CMP:
            begin
                ram_req.we = 1'b1;
                if (shift_up)
                begin
                    ram_req.wdata = ram_rdata;
                    wptr_next     = ptr_reg;
                    ptr_next      = wrap_dec(ptr_reg);
                    rem_next      = rem_reg - CNT_W'(1);
                    state_next    = S_INS_RD;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    emit.valid = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REM_RD:
            begin
                ram_req.raddr = head_reg;
                state_next    = S_REM_OUT;
            end
            S_REM_OUT:
            begin
                emit.valid            = 1'b1;
                emit.res.out_value    = ram_rdata.value;
                emit.res.out_priority = from_prio(ram_rdata.prio);
                head_next             = wrap_inc(head_reg);
                count_next            = count_reg - CNT_W'(1);
                state_next            = S_IDLE;
            end
            S_DUMP_RD:
            begin
                ptr_next   = wrap_inc(ptr_reg);
                rem_next   = rem_reg - CNT_W'(1);
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                emit.valid            = 1'b1;
                emit.res.out_value    = ram_rdata.value;
                emit.res.out_priority = from_prio(ram_rdata.prio);
                emit.res.last         = (rem_reg == '0);
                state_next            = (rem_reg == '0) ? S_IDLE : S_DUMP_RD;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
            ptr_reg   <= '0;
            wptr_reg  <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            ptr_reg   <= ptr_next;
            wptr_reg  <= wptr_next;
            rem_reg   <= rem_next;
        end
    end

    // Entry being inserted
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    // Fill level never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // No result beat while idle without a new command
    a_no_spurious_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !start) |-> !emit.valid)
        else $error("result beat without a command");

    // The final beat of a command returns the sequencer to idle
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.valid && emit.res.last) |=> (state_reg == S_IDLE))
        else $error("sequencer busy after final beat");

    // Fill level only moves while a command is in progress
    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> (count_reg == $past(count_reg)))
        else $error("entry count changed while idle");

endmodule

// File: src/sorted_priority_queue.sv
// Top level: sequencer, entry storage and registered result port.
// Insert scans down from the tail, moving each entry of higher priority up one slot.
// A full insert answers straight from idle; remove reads the head; dump gives one beat per entry.
// One command at a time: busy holds until the final beat is issued; the next start may
// land while that beat sits on the result port, which the receiver cannot stall.
// Reset clears the fill level and head pointer; the storage keeps no reset value.
module sorted_priority_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  spq_pkg::item_t   item,
    output logic             busy,
    output logic             result_valid,
    output spq_pkg::result_t result
);
    import spq_pkg::*;

    ram_req_t ram_req;
    entry_t   ram_rdata;
    emit_t    emit;
    logic     result_valid_reg;
    result_t  result_reg;

    spq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .ram_rdata (ram_rdata),
        .busy      (busy),
        .ram_req   (ram_req),
        .emit      (emit)
    );

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= emit.valid;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit.valid)
            result_reg <= emit.res;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: tb/spq_checker.sv
// Checker for the sorted priority queue: predicts every result beat and compares.
module spq_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  spq_pkg::item_t   item,
    input  logic             result_valid,
    input  spq_pkg::result_t result,
    output int               mismatches,
    output int               outstanding
);
    import spq_pkg::*;

    // Predicted queue contents, head at index 0
    logic [31:0]       held_values [CAPACITY];
    logic [PRIO_W-1:0] held_prios  [CAPACITY];
    int                held_count;

    // Result beats still owed by the block, oldest first
    result_t pending_beats [$];

    task automatic owe_beat(input logic [1:0] st, input logic [31:0] value,
                            input logic [PRIO_W-1:0] prio, input logic lst);
        result_t beat;
        beat.status       = st;
        beat.out_value    = value;
        beat.out_priority = 8'(prio);
        beat.last         = lst;
        pending_beats.push_back(beat);
    endtask

    // Update the predicted queue for one accepted command
    task automatic run_command(input item_t cmd_beat);
        logic [PRIO_W-1:0] prio;
        int                pos;
        prio = PRIO_W'(cmd_beat.item_priority);
        case (cmd_beat.cmd)
            CMD_INSERT:
            begin
                if (held_count >= CAPACITY)
                begin
                    owe_beat(STAT_FULL, '0, '0, 1'b1);
                end
                else
                begin
                    // stable insert: goes behind every entry of equal priority
                    pos = 0;
                    while (pos < held_count && held_prios[pos] <= prio)
                        pos++;
                    for (int i = held_count; i > pos; i--)
                    begin
                        held_values[i] = held_values[i-1];
                        held_prios[i]  = held_prios[i-1];
                    end
                    held_values[pos] = cmd_beat.item_value;
                    held_prios[pos]  = prio;
                    held_count++;
                    owe_beat(STAT_OK, '0, '0, 1'b1);
                end
            end
            CMD_REMOVE:
            begin
                if (held_count == 0)
                begin
                    owe_beat(STAT_EMPTY, '0, '0, 1'b1);
                end
                else
                begin
                    owe_beat(STAT_OK, held_values[0], held_prios[0], 1'b1);
                    for (int i = 1; i < held_count; i++)
                    begin
                        held_values[i-1] = held_values[i];
                        held_prios[i-1]  = held_prios[i];
                    end
                    held_count--;
                end
            end
            CMD_DUMP:
            begin
                if (held_count == 0)
                    owe_beat(STAT_EMPTY, '0, '0, 1'b1);
                else
                    for (int i = 0; i < held_count; i++)
                        owe_beat(STAT_OK, held_values[i], held_prios[i],
                                 i == held_count - 1);
            end
            default:
            begin
                // unassigned command: no effect, plain ok beat
                owe_beat(STAT_OK, '0, '0, 1'b1);
            end
        endcase
    endtask

    // Compare the beat on the port first; a new command may land on the same edge
    always @(posedge clk or negedge rst_n)
    begin : watch_beats
        result_t want;
        if (!rst_n)
        begin
            held_count = 0;
            pending_beats.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (pending_beats.size() == 0)
                begin
                    $display("%0t: unexpected result beat:", $time);
                    $display("%0t:           actual   status=%0d value=%0d prio=%0d last=%0b",
                             $time, result.status, result.out_value, result.out_priority,
                             result.last);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = pending_beats.pop_front();
                    if (result.status !== want.status || result.out_value !== want.out_value ||
                        result.out_priority !== want.out_priority || result.last !== want.last)
                    begin
                        $display("%0t: mismatch: expected status=%0d value=%0d prio=%0d last=%0b",
                                 $time, want.status, want.out_value, want.out_priority,
                                 want.last);
                        $display("%0t:           actual   status=%0d value=%0d prio=%0d last=%0b",
                                 $time, result.status, result.out_value, result.out_priority,
                                 result.last);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (start && !busy)
                run_command(item);
            outstanding <= pending_beats.size();
        end
    end

endmodule

// File: tb/tb_sorted_priority_queue.sv
// Testbench top for the sorted priority queue: clock, reset, command stimulus, verdict.
module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;   // no command assigned to this code
    localparam int         RANDOM_ITEMS = 95;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         TAIL_CYCLES  = 40;

    logic    clk    = 1'b0;
    logic    rst_n  = 1'b0;
    logic    start  = 1'b0;
    item_t   item   = '0;
    logic    busy;
    logic    result_valid;
    result_t result;
    int      mismatches;
    int      outstanding;
    int      idle_cycles = 0;
    bit      no_gaps     = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_priority_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    spq_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // Watchdog: cycles in which no command and no result beat is accepted
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones; none during a no-gap stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Values lean on the extremes now and then
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Narrow range half the time so equal priorities are common
    function automatic logic [7:0] pick_priority();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 8'($urandom_range(0, 3));
        else if (r == 5)
            return 8'h00;
        else if (r == 6)
            return 8'hff;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Hold the command on the port until the block takes it
    task automatic send_command(input logic [1:0] cmd, input logic [31:0] value,
                                input logic [7:0] prio);
        item_t beat;
        int    gap;
        beat.cmd           = cmd;
        beat.item_value    = value;
        beat.item_priority = prio;
        start <= 1'b1;
        item  <= beat;
        do
            @(posedge clk);
        while (busy);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending until every owed result beat has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int       sent;
        int       round;
        int       run_len;
        int       insert_pct;
        int       pick;
        logic [1:0] cmd;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queue cases and the unassigned command
        send_command(CMD_REMOVE, $urandom, 8'($urandom_range(0, 255)));
        send_command(CMD_DUMP, $urandom, 8'($urandom_range(0, 255)));
        send_command(CMD_UNUSED, $urandom, 8'($urandom_range(0, 255)));
        // extremes of value and priority, ties kept in arrival order
        send_command(CMD_INSERT, 32'h7fff_ffff, 8'hff);
        send_command(CMD_INSERT, 32'h8000_0000, 8'h00);
        send_command(CMD_INSERT, 32'h0000_0000, 8'h00);
        send_command(CMD_INSERT, 32'hffff_ffff, 8'hff);
        send_command(CMD_DUMP, $urandom, 8'($urandom_range(0, 255)));
        send_command(CMD_REMOVE, $urandom, 8'($urandom_range(0, 255)));
        // fill to capacity, then overflow, full dump and a remove
        for (int k = 0; k < CAPACITY - 3; k++)
            send_command(CMD_INSERT, $urandom, 8'($urandom_range(0, 255)));
        send_command(CMD_INSERT, $urandom, 8'($urandom_range(0, 255)));
        send_command(CMD_DUMP, $urandom, 8'($urandom_range(0, 255)));
        send_command(CMD_REMOVE, $urandom, 8'($urandom_range(0, 255)));
        drain_results();

        // Random runs, each leaning toward filling, draining or neither
        sent  = 0;
        round = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                default: insert_pct = 50;
            endcase
            run_len = $urandom_range(8, 24);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (round == 2 || $urandom_range(0, 4) == 0)
                drain_results();
            for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                begin
                    // noise beat, not counted
                    send_command(CMD_UNUSED, $urandom, 8'($urandom_range(0, 255)));
                end
                else
                begin
                    if (pick < 10)
                        cmd = CMD_DUMP;
                    else if ($urandom_range(0, 99) < insert_pct)
                        cmd = CMD_INSERT;
                    else
                        cmd = CMD_REMOVE;
                    send_command(cmd, pick_value(), pick_priority());
                    sent++;
                end
            end
            round++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
